>>> rtl/core/assert_macros.svh
// Assertion macros shared by the tokenizer checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define AST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle outside reset.
`define AST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ast_pkg.sv
// Types, constants and character helpers of the assembler source tokenizer.
`default_nettype none

package ast_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_WORD_DEF     = 32;
  localparam int MAX_LITERAL_DEF  = 64;
  localparam int OFFSET_WIDTH_DEF = 32;

  // Field widths
  localparam int CNT_W    = 7;
  localparam int START_W  = 32;
  localparam int NTABLE   = 14;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int FCNT_W     = 3;

  // Character codes
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_E_LOWER = 8'h65;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef enum logic [2:0] {
    KIND_INT      = 3'd0,
    KIND_REAL     = 3'd1,
    KIND_KEYWORD  = 3'd2,
    KIND_DATATYPE = 3'd3,
    KIND_WORD     = 3'd4,
    KIND_PUNCT    = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MALFORMED = 3'd1,
    ERR_LIT_LONG  = 3'd2,
    ERR_WORD_LONG = 3'd3,
    ERR_UNKNOWN   = 3'd4
  } err_e;

  // Scanner mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WORD = 3'b010,
    MODE_NUM  = 3'b100
  } mode_e;

  typedef struct packed {
    kind_e              kind;
    logic [START_W-1:0] start;
    logic [CNT_W-1:0]   len;
    logic [3:0]         idx;
    err_e               err;
    logic               last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c > 8'h2f) && (c < 8'h3a);
  endfunction

  function automatic logic is_alpha_byte(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    return (l > 8'h60) && (l < 8'h7b);
  endfunction

  function automatic logic is_word_part(input logic [7:0] c);
    return is_alpha_byte(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h0a, 8'h0d, 8'h09, 8'h0b, 8'h0c};
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {8'h2e, 8'h3a, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h28, 8'h29};
  endfunction

  function automatic logic is_num_part(input logic [7:0] c, input logic hex);
    logic [7:0] l;
    l = c | CASE_BIT;
    return is_digit(c) || (hex && (l > 8'h60) && (l < 8'h67)) || (c == CH_DOT) ||
           (l == CH_E_LOWER);
  endfunction

  // Name list: keyword first, then the datatypes
  function automatic logic [63:0] name_str(input logic [3:0] i);
    logic [63:0] s;
    case (i)
      4'd0:    s = "halt";
      4'd1:    s = "byte";
      4'd2:    s = "sbyte";
      4'd3:    s = "ushort";
      4'd4:    s = "short";
      4'd5:    s = "uint";
      4'd6:    s = "int";
      4'd7:    s = "ulong";
      4'd8:    s = "long";
      4'd9:    s = "single";
      4'd10:   s = "double";
      4'd11:   s = "function";
      4'd12:   s = "node";
      4'd13:   s = "list";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] name_len(input logic [3:0] i);
    logic [3:0] n;
    case (i)
      4'd0, 4'd1, 4'd5, 4'd8, 4'd12, 4'd13: n = 4'd4;
      4'd2, 4'd4, 4'd7:                     n = 4'd5;
      4'd3, 4'd9, 4'd10:                    n = 4'd6;
      4'd6:                                 n = 4'd3;
      4'd11:                                n = 4'd8;
      default:                              n = 4'd0;
    endcase
    return n;
  endfunction

  // Byte k of name i, counted from the first letter
  function automatic logic [7:0] name_char(input logic [3:0] i, input logic [2:0] k);
    logic [63:0] s;
    logic [3:0]  sh;
    s  = name_str(i);
    sh = name_len(i) - 4'd1 - {1'b0, k};
    return 8'(s >> {sh, 3'b000});
  endfunction

  // Names that still agree with byte c at position k
  function automatic logic [NTABLE-1:0] match_mask(input logic [CNT_W-1:0] k,
                                                   input logic [7:0] c);
    logic [NTABLE-1:0] m;
    for (int i = 0; i < NTABLE; i++) begin
      m[i] = (k < CNT_W'(name_len(4'(i)))) && (name_char(4'(i), k[2:0]) == c);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ast_chan_if.sv
// Request channels of the tokenizer: source bytes in, token descriptors out.
`default_nettype none

interface ast_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface ast_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] start_offset;
  logic [6:0]  token_length;
  logic [3:0]  table_index;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output token_kind, output start_offset, output token_length,
                  output table_index, output error_code, output last, input ready);
  modport sink   (input valid, input token_kind, input start_offset, input token_length,
                  input table_index, input error_code, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/assembler_source_tokenizer_top.sv
// Top level of the assembler source tokenizer: scanner state and result queue.
`default_nettype none

// Streaming lexer for assembler source. Each input request carries one source
// byte or an end mark; the scanner state is updated in the cycle the request is
// accepted and the tokens it completes (none, one or two) are pushed into a
// four-entry result queue, the last of them flagged with last; the queue offers
// them on the output in order, behind any tokens already queued. An input request
// is taken in every cycle while the queue has room for two results, so the block
// scans one byte per clock; the queue drains one token per clock while out_o.ready
// is high, which limits the input rate only while bytes complete more than one
// token each on average. The keyword and datatype names are matched on the fly
// with a 14-bit match vector. The first error token halts the scanner: later
// requests are accepted and dropped until reset. start_offset counts source
// bytes modulo 2^OFFSET_WIDTH.
module assembler_source_tokenizer_top #(
  parameter int MAX_WORD     = ast_pkg::MAX_WORD_DEF,
  parameter int MAX_LITERAL  = ast_pkg::MAX_LITERAL_DEF,
  parameter int OFFSET_WIDTH = ast_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ast_in_if.sink     in_i,
  ast_out_if.source  out_o
);

  localparam int CW = ast_pkg::CNT_W;
  localparam int NT = ast_pkg::NTABLE;
  localparam int PW = ast_pkg::PTR_W;
  localparam int FW = ast_pkg::FCNT_W;
  localparam logic [CW-1:0] MaxWordC = CW'(MAX_WORD);
  localparam logic [CW-1:0] MaxLitC  = CW'(MAX_LITERAL);
  localparam logic [FW-1:0] RoomC    = FW'(ast_pkg::FIFO_DEPTH - 2);

  // Scanner state
  ast_pkg::mode_e           mode_q, mode_d;
  logic [OFFSET_WIDTH-1:0]  start_q, start_d;
  logic [OFFSET_WIDTH-1:0]  pos_q, pos_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     real_q, real_d;
  logic                     hex_q, hex_d;
  logic                     lz_q, lz_d;
  logic [NT-1:0]            mv_q, mv_d;
  logic                     halted_q, halted_d;

  // Result queue
  ast_pkg::tok_t            fifo_q [ast_pkg::FIFO_DEPTH];
  logic [PW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]            fcnt_q, fcnt_d;

  logic                     in_fire, out_fire;
  logic [7:0]               c;
  ast_pkg::tok_t            flush_r;
  ast_pkg::tok_t            res [2];
  logic [1:0]               n_res;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign c        = in_i.character;

  // Token closed by the open word or literal
  always_comb begin
    flush_r       = '0;
    flush_r.start = ast_pkg::START_W'(start_q);
    flush_r.len   = cnt_q;
    flush_r.err   = ast_pkg::ERR_NONE;
    if (mode_q == ast_pkg::MODE_WORD) begin
      flush_r.kind = ast_pkg::KIND_WORD;
      for (int i = NT - 1; i >= 0; i--) begin
        if (mv_q[i] && (CW'(ast_pkg::name_len(4'(i))) == cnt_q)) begin
          flush_r.kind = (i == 0) ? ast_pkg::KIND_KEYWORD : ast_pkg::KIND_DATATYPE;
          flush_r.idx  = (i == 0) ? 4'd0 : 4'(i - 1);
        end
      end
    end else begin
      flush_r.kind = real_q ? ast_pkg::KIND_REAL : ast_pkg::KIND_INT;
    end
  end

  // Per-byte scanner step
  always_comb begin
    logic fresh;
    logic take_x;
    mode_d   = mode_q;
    start_d  = start_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    real_d   = real_q;
    hex_d    = hex_q;
    lz_d     = lz_q;
    mv_d     = mv_q;
    halted_d = halted_q;
    res[0]   = '0;
    res[1]   = '0;
    n_res    = 2'd0;
    fresh    = 1'b0;
    take_x   = 1'b0;

    if (in_fire && !halted_q) begin
      if (in_i.end_of_input) begin
        // End mark: flush only
        if (mode_q != ast_pkg::MODE_IDLE) begin
          res[0] = flush_r;
          n_res  = 2'd1;
        end
        mode_d = ast_pkg::MODE_IDLE;
      end else begin
        fresh = 1'b1;
        case (mode_q)
          ast_pkg::MODE_WORD: begin
            if (ast_pkg::is_word_part(c)) begin
              fresh = 1'b0;
              if (cnt_q >= MaxWordC) begin
                res[0].kind  = ast_pkg::KIND_ERROR;
                res[0].start = ast_pkg::START_W'(start_q);
                res[0].len   = cnt_q;
                res[0].err   = ast_pkg::ERR_WORD_LONG;
                n_res        = 2'd1;
                halted_d     = 1'b1;
                mode_d       = ast_pkg::MODE_IDLE;
              end else begin
                mv_d  = mv_q & ast_pkg::match_mask(cnt_q, c);
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              res[0] = flush_r;
              n_res  = 2'd1;
              mode_d = ast_pkg::MODE_IDLE;
            end
          end
          ast_pkg::MODE_NUM: begin
            take_x = lz_q && (cnt_q == CW'(1)) && ((c | ast_pkg::CASE_BIT) == ast_pkg::CH_X_LOWER);
            lz_d   = 1'b0;
            if (take_x || ast_pkg::is_num_part(c, hex_q)) begin
              fresh = 1'b0;
              if (cnt_q >= MaxLitC) begin
                res[0].kind  = ast_pkg::KIND_ERROR;
                res[0].start = ast_pkg::START_W'(start_q);
                res[0].len   = cnt_q;
                res[0].err   = ast_pkg::ERR_LIT_LONG;
                n_res        = 2'd1;
                halted_d     = 1'b1;
                mode_d       = ast_pkg::MODE_IDLE;
              end else if (take_x) begin
                hex_d = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end else if ((c == ast_pkg::CH_DOT) && (real_q || hex_q)) begin
                res[0].kind  = ast_pkg::KIND_ERROR;
                res[0].start = ast_pkg::START_W'(start_q);
                res[0].len   = cnt_q + 1'b1;
                res[0].err   = ast_pkg::ERR_MALFORMED;
                n_res        = 2'd1;
                halted_d     = 1'b1;
                mode_d       = ast_pkg::MODE_IDLE;
              end else begin
                if (c == ast_pkg::CH_DOT) real_d = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              res[0] = flush_r;
              n_res  = 2'd1;
              mode_d = ast_pkg::MODE_IDLE;
            end
          end
          default: begin
            mode_d = ast_pkg::MODE_IDLE;
          end
        endcase

        // Byte that starts something new
        if (fresh) begin
          if (ast_pkg::is_space(c)) begin
            // separator only
          end else if (ast_pkg::is_punct(c)) begin
            res[n_res[0]].kind  = ast_pkg::KIND_PUNCT;
            res[n_res[0]].start = ast_pkg::START_W'(pos_q);
            res[n_res[0]].len   = CW'(1);
            res[n_res[0]].err   = ast_pkg::ERR_NONE;
            n_res               = n_res + 2'd1;
          end else if (ast_pkg::is_alpha_byte(c) || (c == ast_pkg::CH_UNDER)) begin
            mode_d  = ast_pkg::MODE_WORD;
            start_d = pos_q;
            cnt_d   = CW'(1);
            mv_d    = ast_pkg::match_mask('0, c);
          end else if (ast_pkg::is_digit(c) || (c == ast_pkg::CH_MINUS)) begin
            mode_d  = ast_pkg::MODE_NUM;
            start_d = pos_q;
            cnt_d   = CW'(1);
            real_d  = 1'b0;
            hex_d   = 1'b0;
            lz_d    = (c == ast_pkg::CH_ZERO);
          end else begin
            res[n_res[0]].kind  = ast_pkg::KIND_ERROR;
            res[n_res[0]].start = ast_pkg::START_W'(pos_q);
            res[n_res[0]].len   = CW'(1);
            res[n_res[0]].err   = ast_pkg::ERR_UNKNOWN;
            n_res               = n_res + 2'd1;
            halted_d            = 1'b1;
            mode_d              = ast_pkg::MODE_IDLE;
          end
        end
        pos_d = pos_q + 1'b1;
      end
    end

    // Flag the final token of this byte
    if (n_res == 2'd1) res[0].last = 1'b1;
    if (n_res == 2'd2) res[1].last = 1'b1;
  end

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(n_res);
    rd_ptr_d = rd_ptr_q + PW'(out_fire);
    fcnt_d   = fcnt_q + FW'(n_res) - FW'(out_fire);
  end

  // Control and scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ast_pkg::MODE_IDLE;
      start_q  <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      real_q   <= 1'b0;
      hex_q    <= 1'b0;
      lz_q     <= 1'b0;
      mv_q     <= '1;
      halted_q <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      real_q   <= real_d;
      hex_q    <= hex_d;
      lz_q     <= lz_d;
      mv_q     <= mv_d;
      halted_q <= halted_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fcnt_q   <= fcnt_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_ptr_q] <= res[0];
    if (n_res == 2'd2) fifo_q[wr_ptr_q + 1'b1] <= res[1];
  end

  // Ports
  assign in_i.ready         = (fcnt_q <= RoomC);
  assign out_o.valid        = (fcnt_q != '0);
  assign out_o.token_kind   = fifo_q[rd_ptr_q].kind;
  assign out_o.start_offset = fifo_q[rd_ptr_q].start;
  assign out_o.token_length = fifo_q[rd_ptr_q].len;
  assign out_o.table_index  = fifo_q[rd_ptr_q].idx;
  assign out_o.error_code   = fifo_q[rd_ptr_q].err;
  assign out_o.last         = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire

>>> rtl/core/ast_checker.sv
// Port-level checker of the tokenizer and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module ast_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] token_kind_i,
  input wire logic [6:0] token_length_i,
  input wire logic [3:0] table_index_i,
  input wire logic [2:0] error_code_i
);

  logic is_err, is_punct, is_dtype;
  assign is_err   = (token_kind_i == ast_pkg::KIND_ERROR);
  assign is_punct = (token_kind_i == ast_pkg::KIND_PUNCT);
  assign is_dtype = (token_kind_i == ast_pkg::KIND_DATATYPE);

  // A stalled token stays offered
  `AST_ASSERT(a_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i, "token dropped while stalled")

  // Error code is set exactly on error tokens
  `AST_ASSERT_IMP(a_err_code, out_valid_i, is_err == (error_code_i != ast_pkg::ERR_NONE), "error code mismatch")

  // Nothing follows a delivered error token
  `AST_ASSERT(a_halt, out_valid_i && out_ready_i && is_err |=> !out_valid_i, "token after halt")

  // Only datatypes carry a nonzero list index
  `AST_ASSERT_IMP(a_index, out_valid_i && !is_dtype, table_index_i == 4'd0, "stray table index")

  // Punctuation is a single byte
  `AST_ASSERT_IMP(a_punct_len, out_valid_i && is_punct, token_length_i == 7'd1, "punctuation length")

endmodule

bind assembler_source_tokenizer_top ast_checker u_ast_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .token_length_i (out_o.token_length),
  .table_index_i  (out_o.table_index),
  .error_code_i   (out_o.error_code)
);

`default_nettype wire
